### rtl/htd_pkg.sv
package htd_pkg;

    typedef logic [63:0] t_u64;
    typedef logic signed [63:0] t_s64;

    typedef enum logic [1:0] {
        CFG_FRONT_LAT = 2'd0,
        CFG_FRONT_LON = 2'd1,
        CFG_BACK_LAT  = 2'd2,
        CFG_BACK_LON  = 2'd3
    } t_cfg_idx;

    localparam int DIFF_W     = 34;
    localparam int MAG_W      = 31;
    localparam int DIST_W     = 25;
    localparam int VEC_W      = 36;
    localparam int SQRT_STEPS = 32;
    localparam int N_SIN      = 4;
    localparam int N_ANG      = 7;

    localparam logic signed [DIFF_W-1:0] U90  = 34'sd900000000;
    localparam logic signed [DIFF_W-1:0] U180 = 34'sd1800000000;
    localparam logic signed [DIFF_W-1:0] U360 = 34'sd3600000000;

    localparam t_u64 PI_Q60       = 64'h3243F6A8885A308D;
    localparam t_u64 RAD_Q60      = (PI_Q60 + 64'd900000000) / 64'd1800000000;
    localparam t_u64 INV_GAIN_Q32 = 64'h9B74EDA8;
    localparam logic [22:0] EARTH_R = 23'd6371000;
    localparam logic [23:0] TWO_R   = 24'd12742000;

    // shift-subtract division, elaboration only
    function automatic t_u64 udiv(input t_u64 n, input t_u64 d);
        t_u64 q;
        t_u64 r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Qf, series in Q62 then rounded half up
    function automatic t_s64 atan_q(input int i, input int f);
        t_s64 acc;
        t_u64 v;
        t_u64 t;
        acc = '0;
        if (i == 0) begin
            v = PI_Q60;
        end else begin
            for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                t = udiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
                if (k % 2 == 1) acc = acc - $signed(t);
                else acc = acc + $signed(t);
            end
            v = $unsigned(acc);
        end
        return $signed((v + (64'd1 << (61 - f))) >> (62 - f));
    endfunction

    function automatic t_s64 inv_gain_q(input int f);
        if (f >= 32) return $signed(INV_GAIN_Q32 << (f - 32));
        else return $signed((INV_GAIN_Q32 + (64'd1 << (31 - f))) >> (32 - f));
    endfunction

    function automatic t_s64 half_pi_q(input int f);
        return $signed((PI_Q60 + (64'd1 << (60 - f))) >> (61 - f));
    endfunction

endpackage

### rtl/haversine_target_distances.sv
// throughput: one item per cycle; busy stays low, every stage is a register row
// sine/cosine, square root and atan2 are rows of cordic and root cells, one step each
// reset (synchronous, active low) clears targets to zero and drops items in flight
// results are strobed for one cycle by o_done; the receiver cannot stall
module haversine_target_distances #(
    parameter int CORDIC_STEPS    = 32,
    parameter int ANGLE_FRAC_BITS = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_fix_ok,
    input  logic signed [30:0] i_pos_lat,
    input  logic signed [31:0] i_pos_lon,
    output logic        o_done,
    output logic        o_dist_ok,
    output logic [24:0] o_front_dist,
    output logic [24:0] o_back_dist,
    output logic [24:0] o_mid_dist
);
    localparam int S     = CORDIC_STEPS;
    localparam int F     = ANGLE_FRAC_BITS;
    localparam int W     = F + 3;
    localparam int AW    = F + 1;
    localparam int PW    = F + 25;
    localparam int LAT   = 2 * S + 49;
    localparam int DW    = htd_pkg::DIFF_W;
    localparam int MW    = htd_pkg::MAG_W;
    localparam int VW    = htd_pkg::VEC_W;
    localparam int NS    = htd_pkg::N_SIN;
    localparam int NA    = htd_pkg::N_ANG;
    localparam int QS    = htd_pkg::SQRT_STEPS;
    localparam int SH_S  = 61 - F;
    localparam int SH_C  = 60 - F;

    localparam logic [MW-1:0]      RAD31 = htd_pkg::RAD_Q60[MW-1:0];
    localparam logic signed [W-1:0] INV  = W'(htd_pkg::inv_gain_q(F));
    localparam logic signed [W-1:0] HP   = W'(htd_pkg::half_pi_q(F));
    localparam logic signed [W:0]   ONE_S = (W + 1)'(64'd1 << F);
    localparam logic [AW-1:0]       ONE_A = AW'(64'd1 << F);

    // configuration
    logic signed [30:0] r_front_lat;
    logic signed [31:0] r_front_lon;
    logic signed [30:0] r_back_lat;
    logic signed [31:0] r_back_lon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_lat <= '0;
            r_front_lon <= '0;
            r_back_lat  <= '0;
            r_back_lon  <= '0;
        end else if (i_cfg_we) begin
            unique case (htd_pkg::t_cfg_idx'(i_cfg_idx))
                htd_pkg::CFG_FRONT_LAT: r_front_lat <= i_cfg_data[30:0];
                htd_pkg::CFG_FRONT_LON: r_front_lon <= i_cfg_data;
                htd_pkg::CFG_BACK_LAT:  r_back_lat  <= i_cfg_data[30:0];
                htd_pkg::CFG_BACK_LON:  r_back_lon  <= i_cfg_data;
            endcase
        end
    end

    // item tracking
    logic           n_acc;
    logic [LAT-1:0] r_act;
    logic [LAT-1:0] r_fix;

    assign busy  = 1'b0;
    assign n_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= '0;
        end else begin
            r_act <= {r_act[LAT-2:0], n_acc};
        end
        r_fix <= {r_fix[LAT-2:0], i_fix_ok};
    end

    // stage 1: differences, lanes 0..3 sine halves, 4..6 cosines
    logic signed [DW-1:0] r_s1_d [NA];

    always_ff @(posedge i_clk) begin
        r_s1_d[0] <= DW'(r_front_lat) - DW'(i_pos_lat);
        r_s1_d[1] <= DW'(r_front_lon) - DW'(i_pos_lon);
        r_s1_d[2] <= DW'(r_back_lat) - DW'(i_pos_lat);
        r_s1_d[3] <= DW'(r_back_lon) - DW'(i_pos_lon);
        r_s1_d[4] <= DW'(i_pos_lat);
        r_s1_d[5] <= DW'(r_front_lat);
        r_s1_d[6] <= DW'(r_back_lat);
    end

    // stage 2: truncating modulo 360 deg, or cosine fold about 90 deg
    logic signed [DW-1:0] n_s2_v [NA];
    logic [NA-NS-1:0]     n_s2_neg;
    logic signed [DW-1:0] r_s2_v [NA];
    logic [NA-NS-1:0]     r_s2_neg;

    always_comb begin
        n_s2_neg = '0;
        for (int j = 0; j < NA; j++) begin
            n_s2_v[j] = r_s1_d[j];
            if (j < NS) begin
                if (r_s1_d[j] >= htd_pkg::U360) n_s2_v[j] = r_s1_d[j] - htd_pkg::U360;
                else if (r_s1_d[j] <= -htd_pkg::U360) n_s2_v[j] = r_s1_d[j] + htd_pkg::U360;
            end else begin
                if (r_s1_d[j] > htd_pkg::U90) begin
                    n_s2_v[j] = htd_pkg::U180 - r_s1_d[j];
                    n_s2_neg[j - NS] = 1'b1;
                end else if (r_s1_d[j] < -htd_pkg::U90) begin
                    n_s2_v[j] = -htd_pkg::U180 - r_s1_d[j];
                    n_s2_neg[j - NS] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_v   <= n_s2_v;
        r_s2_neg <= n_s2_neg;
    end

    // stage 3: wrap into [-180, 180) deg, then magnitude
    logic [MW-1:0]    n_s3_u [NA];
    logic [MW-1:0]    r_s3_u [NA];
    logic [NA-NS-1:0] r_s3_neg;

    always_comb begin
        logic signed [DW-1:0] t;
        t = '0;
        for (int j = 0; j < NA; j++) begin
            t = r_s2_v[j];
            if (j < NS) begin
                if (t >= htd_pkg::U180) t = t - htd_pkg::U360;
                else if (t < -htd_pkg::U180) t = t + htd_pkg::U360;
            end
            n_s3_u[j] = t[DW-1] ? MW'(-t) : MW'(t);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_u   <= n_s3_u;
        r_s3_neg <= r_s2_neg;
    end

    // stages 4, 5: degree units to radians, halved on the sine lanes
    logic [2*MW-1:0]     r_s4_p [NA];
    logic signed [W-1:0] r_s5_t [NA];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NA; j++) begin
            r_s4_p[j] <= {{MW{1'b0}}, r_s3_u[j]} * {{MW{1'b0}}, RAD31};
            if (j < NS) begin
                r_s5_t[j] <= W'((64'(r_s4_p[j]) + (64'd1 << (SH_S - 1))) >> SH_S);
            end else begin
                r_s5_t[j] <= W'((64'(r_s4_p[j]) + (64'd1 << (SH_C - 1))) >> SH_C);
            end
        end
    end

    // cosine fold flags ride alongside the rotation rows
    logic [NA-NS-1:0] r_negd [S+2];

    always_ff @(posedge i_clk) begin
        r_negd[0] <= r_s3_neg;
        for (int k = 1; k < S + 2; k++) r_negd[k] <= r_negd[k-1];
    end

    // rotation rows
    wire signed [W-1:0] w_rx [NA][S+1];
    wire signed [W-1:0] w_ry [NA][S+1];
    wire signed [W-1:0] w_rz [NA][S+1];

    for (genvar j = 0; j < NA; j++) begin : g_rot
        assign w_rx[j][0] = INV;
        assign w_ry[j][0] = '0;
        assign w_rz[j][0] = r_s5_t[j];
        for (genvar i = 0; i < S; i++) begin : g_cell
            htd_rot_cell #(.W(W), .F(F), .IDX(i)) u_cell (
                .i_clk (i_clk),
                .i_x   (w_rx[j][i]),
                .i_y   (w_ry[j][i]),
                .i_z   (w_rz[j][i]),
                .o_x   (w_rx[j][i+1]),
                .o_y   (w_ry[j][i+1]),
                .o_z   (w_rz[j][i+1])
            );
        end
    end

    logic signed [W-1:0] r_m0 [NA];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NA; j++) begin
            if (j < NS) r_m0[j] <= w_ry[j][S];
            else if (r_negd[S+1][j - NS]) r_m0[j] <= -w_rx[j][S];
            else r_m0[j] <= w_rx[j][S];
        end
    end

    // squares of sines and the cosine products
    wire signed [W-1:0] w_q [6];
    wire signed [W-1:0] w_p [2];

    for (genvar j = 0; j < NS; j++) begin : g_sq
        htd_mulq #(.WI(W), .F(F)) u_sq (
            .i_clk (i_clk), .i_a (r_m0[j]), .i_b (r_m0[j]), .o_p (w_q[j])
        );
    end

    htd_mulq #(.WI(W), .F(F)) u_ccf (
        .i_clk (i_clk), .i_a (r_m0[4]), .i_b (r_m0[5]), .o_p (w_q[4])
    );
    htd_mulq #(.WI(W), .F(F)) u_ccb (
        .i_clk (i_clk), .i_a (r_m0[4]), .i_b (r_m0[6]), .o_p (w_q[5])
    );
    htd_mulq #(.WI(W), .F(F)) u_pf (
        .i_clk (i_clk), .i_a (w_q[4]), .i_b (w_q[1]), .o_p (w_p[0])
    );
    htd_mulq #(.WI(W), .F(F)) u_pb (
        .i_clk (i_clk), .i_a (w_q[5]), .i_b (w_q[3]), .o_p (w_p[1])
    );

    logic signed [W-1:0] r_sqd [3][2];

    always_ff @(posedge i_clk) begin
        r_sqd[0][0] <= w_q[0];
        r_sqd[0][1] <= w_q[2];
        for (int k = 1; k < 3; k++) r_sqd[k] <= r_sqd[k-1];
    end

    // haversine term, clamped to [0, 1]
    logic [AW-1:0] n_a [2];
    logic [AW-1:0] r_a [2];
    logic [63:0]   r_sv [4];

    always_comb begin
        logic signed [W:0] sm;
        sm = '0;
        for (int t = 0; t < 2; t++) begin
            sm = (W + 1)'(r_sqd[2][t]) + (W + 1)'(w_p[t]);
            if (sm < 0) n_a[t] = '0;
            else if (sm > ONE_S) n_a[t] = ONE_A;
            else n_a[t] = AW'(sm);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        for (int t = 0; t < 2; t++) begin
            r_sv[2*t]   <= 64'(r_a[t]) << (62 - F);
            r_sv[2*t+1] <= 64'(ONE_A - r_a[t]) << (62 - F);
        end
    end

    // square root rows: sqrt(a) and sqrt(1 - a) per target
    wire [63:0] w_sv [4][QS+1];
    wire [63:0] w_sr [4][QS+1];

    for (genvar l = 0; l < 4; l++) begin : g_sqrt
        assign w_sv[l][0] = r_sv[l];
        assign w_sr[l][0] = '0;
        for (genvar i = 0; i < QS; i++) begin : g_cell
            htd_sqrt_cell #(.IDX(i)) u_cell (
                .i_clk (i_clk),
                .i_v   (w_sv[l][i]),
                .i_res (w_sr[l][i]),
                .o_v   (w_sv[l][i+1]),
                .o_res (w_sr[l][i+1])
            );
        end
    end

    // vectoring rows: atan2(sqrt(a), sqrt(1 - a))
    wire signed [VW-1:0] w_vx [2][S+1];
    wire signed [VW-1:0] w_vy [2][S+1];
    wire signed [W-1:0]  w_vz [2][S+1];

    for (genvar t = 0; t < 2; t++) begin : g_vec
        assign w_vy[t][0] = VW'(w_sr[2*t][QS]);
        assign w_vx[t][0] = VW'(w_sr[2*t+1][QS]);
        assign w_vz[t][0] = '0;
        for (genvar i = 0; i < S; i++) begin : g_cell
            htd_vec_cell #(.WV(VW), .W(W), .F(F), .IDX(i)) u_cell (
                .i_clk (i_clk),
                .i_x   (w_vx[t][i]),
                .i_y   (w_vy[t][i]),
                .i_z   (w_vz[t][i]),
                .o_x   (w_vx[t][i+1]),
                .o_y   (w_vy[t][i+1]),
                .o_z   (w_vz[t][i+1])
            );
        end
    end

    // clamp to [0, pi/2], scale by twice the radius (mid: the sum of both by the radius)
    logic [AW-1:0]   n_zc [2];
    logic [AW-1:0]   r_zc [2];
    logic [AW:0]     r_zs;
    logic [PW-1:0]   r_pf [2];
    logic [PW-1:0]   r_pm;

    always_comb begin
        for (int t = 0; t < 2; t++) begin
            if (w_vz[t][S] < 0) n_zc[t] = '0;
            else if (w_vz[t][S] > HP) n_zc[t] = AW'(HP);
            else n_zc[t] = AW'(w_vz[t][S]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_zc <= n_zc;
        r_zs <= (AW + 1)'(n_zc[0]) + (AW + 1)'(n_zc[1]);
        for (int t = 0; t < 2; t++) r_pf[t] <= PW'(r_zc[t]) * PW'(htd_pkg::TWO_R);
        r_pm <= PW'(r_zs) * PW'(htd_pkg::EARTH_R);
    end

    // result registers, zero distances without a fix
    logic        r_ok;
    logic [24:0] r_fd;
    logic [24:0] r_bd;
    logic [24:0] r_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= 1'b0;
        end else begin
            r_ok <= r_act[LAT-2] && r_fix[LAT-2];
        end
        r_fd <= r_fix[LAT-2] ? htd_pkg::DIST_W'(r_pf[0] >> F) : '0;
        r_bd <= r_fix[LAT-2] ? htd_pkg::DIST_W'(r_pf[1] >> F) : '0;
        r_md <= r_fix[LAT-2] ? htd_pkg::DIST_W'(r_pm >> F) : '0;
    end

    assign o_done       = r_act[LAT-1];
    assign o_dist_ok    = r_ok;
    assign o_front_dist = r_fd;
    assign o_back_dist  = r_bd;
    assign o_mid_dist   = r_md;

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("item accepted but no result after pipeline latency");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted item");

    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dist_ok |-> o_done)
        else $error("dist_ok outside a result strobe");

    a_nofix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_dist_ok) |->
            (o_front_dist == '0 && o_back_dist == '0 && o_mid_dist == '0))
        else $error("nonzero distance without a fix");

    a_mid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dist_ok |-> ((o_mid_dist >= o_front_dist || o_mid_dist >= o_back_dist) &&
                       (o_mid_dist <= o_front_dist || o_mid_dist <= o_back_dist)))
        else $error("mid distance outside front/back range");

endmodule

### rtl/htd_rot_cell.sv
module htd_rot_cell #(
    parameter int W   = 33,
    parameter int F   = 30,
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [W-1:0] i_z,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [W-1:0] o_z
);
    localparam logic signed [W-1:0] ATAN = W'(htd_pkg::atan_q(IDX, F));

    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;

    always_ff @(posedge i_clk) begin
        if (!i_z[W-1]) begin
            r_x <= i_x - (i_y >>> IDX);
            r_y <= i_y + (i_x >>> IDX);
            r_z <= i_z - ATAN;
        end else begin
            r_x <= i_x + (i_y >>> IDX);
            r_y <= i_y - (i_x >>> IDX);
            r_z <= i_z + ATAN;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

### rtl/htd_vec_cell.sv
module htd_vec_cell #(
    parameter int WV  = 36,
    parameter int W   = 33,
    parameter int F   = 30,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic signed [WV-1:0] i_x,
    input  logic signed [WV-1:0] i_y,
    input  logic signed [W-1:0]  i_z,
    output logic signed [WV-1:0] o_x,
    output logic signed [WV-1:0] o_y,
    output logic signed [W-1:0]  o_z
);
    localparam logic signed [W-1:0] ATAN = W'(htd_pkg::atan_q(IDX, F));

    logic signed [WV-1:0] r_x;
    logic signed [WV-1:0] r_y;
    logic signed [W-1:0]  r_z;

    // drive y toward zero, z collects the angle
    always_ff @(posedge i_clk) begin
        if (!i_y[WV-1]) begin
            r_x <= i_x + (i_y >>> IDX);
            r_y <= i_y - (i_x >>> IDX);
            r_z <= i_z + ATAN;
        end else begin
            r_x <= i_x - (i_y >>> IDX);
            r_y <= i_y + (i_x >>> IDX);
            r_z <= i_z - ATAN;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

### rtl/htd_sqrt_cell.sv
module htd_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic [63:0] i_v,
    input  logic [63:0] i_res,
    output logic [63:0] o_v,
    output logic [63:0] o_res
);
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] n_trial;

    assign n_trial = i_res + BIT;

    always_ff @(posedge i_clk) begin
        if (i_v >= n_trial) begin
            r_v   <= i_v - n_trial;
            r_res <= (i_res >> 1) + BIT;
        end else begin
            r_v   <= i_v;
            r_res <= i_res >> 1;
        end
    end

    assign o_v   = r_v;
    assign o_res = r_res;
endmodule

### rtl/htd_mulq.sv
module htd_mulq #(
    parameter int WI = 33,
    parameter int F  = 30
) (
    input  logic                 i_clk,
    input  logic signed [WI-1:0] i_a,
    input  logic signed [WI-1:0] i_b,
    output logic signed [WI-1:0] o_p
);
    logic [WI-1:0]   r_ma;
    logic [WI-1:0]   r_mb;
    logic            r_neg1;
    logic [2*WI-1:0] r_prod;
    logic            r_neg2;
    logic [WI-1:0]   n_sh;
    logic signed [WI-1:0] r_p;

    // sign and magnitude, product truncates toward zero
    assign n_sh = WI'(r_prod >> F);

    always_ff @(posedge i_clk) begin
        r_ma   <= i_a[WI-1] ? WI'(-i_a) : WI'(i_a);
        r_mb   <= i_b[WI-1] ? WI'(-i_b) : WI'(i_b);
        r_neg1 <= i_a[WI-1] ^ i_b[WI-1];
        r_prod <= (2 * WI)'(r_ma) * (2 * WI)'(r_mb);
        r_neg2 <= r_neg1;
        r_p    <= r_neg2 ? $signed(-n_sh) : $signed(n_sh);
    end

    assign o_p = r_p;
endmodule

### verif/haversine_target_distances_test.sv
`timescale 1ns / 1ps

module haversine_target_distances_test;

    localparam int      FRAC       = 30;
    localparam int      STEPS      = 32;
    localparam int      PIPE_DELAY = 2 * STEPS + 60;
    localparam longint  CYCLE_LIMIT = 400000;
    localparam longint  LAT_MAX    = 900000000;
    localparam longint  LON_MAX    = 1800000000;
    localparam longint  DEG90      = 900000000;
    localparam longint  DEG180     = 1800000000;
    localparam longint  DEG360     = 64'sd3600000000;
    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] RAD_UNIT   = (PI_Q60 + 64'd900000000) / 64'd1800000000;
    localparam logic [63:0] GAIN_INV32 = 64'h9B74EDA8;
    localparam logic [63:0] RADIUS     = 64'd6371000;

    typedef struct packed {
        logic        ok;
        logic [24:0] front;
        logic [24:0] back;
        logic [24:0] mid;
    } t_distances;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_fix_ok = 1'b0;
    logic signed [30:0] i_pos_lat = '0;
    logic signed [31:0] i_pos_lon = '0;
    logic               o_done;
    logic               o_dist_ok;
    logic [24:0]        o_front_dist;
    logic [24:0]        o_back_dist;
    logic [24:0]        o_mid_dist;

    haversine_target_distances u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_fix_ok     (i_fix_ok),
        .i_pos_lat    (i_pos_lat),
        .i_pos_lon    (i_pos_lon),
        .o_done       (o_done),
        .o_dist_ok    (o_dist_ok),
        .o_front_dist (o_front_dist),
        .o_back_dist  (o_back_dist),
        .o_mid_dist   (o_mid_dist)
    );

    always #1 i_clk = ~i_clk;

    longint     atan_tab [STEPS];
    longint     gain_inv;
    longint     half_pi;
    longint     tgt_front_lat, tgt_front_lon, tgt_back_lat, tgt_back_lon;
    t_distances pending_dist [$];
    int         errors = 0;
    longint     cycles = 0;
    bit         allow_gaps = 1'b1;

    // ---------------- distance predictor ----------------

    function automatic void init_tables();
        logic [63:0] v;
        longint      acc;
        for (int i = 0; i < STEPS; i++) begin
            if (i == 0) begin
                v = PI_Q60;
            end else begin
                acc = 0;
                for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                    if (k % 2 == 1) acc -= longint'((64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1));
                    else acc += longint'((64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1));
                end
                v = acc;
            end
            atan_tab[i] = (v + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
        end
        gain_inv = (GAIN_INV32 + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
        half_pi  = (PI_Q60 + (64'd1 << (60 - FRAC))) >> (61 - FRAC);
    endfunction

    function automatic logic [63:0] wide_mul_shift(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p >> s);
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic [63:0] ua, ub;
        longint      r;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        r = wide_mul_shift(ua, ub, FRAC);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint units_to_rad(logic [63:0] u, int extra);
        int s;
        s = 60 - FRAC + extra;
        return (u * RAD_UNIT + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic void rotate(longint theta, output longint sn, output longint cs);
        longint x, y, z, dx, dy;
        x = gain_inv;
        y = 0;
        z = theta;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        sn = y;
        cs = x;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > half_pi) z = half_pi;
        return z;
    endfunction

    function automatic logic [63:0] root(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint cos_of_lat(longint u);
        bit     flip;
        longint sn, cs;
        flip = 1'b0;
        if (u > DEG90) begin
            u = DEG180 - u; flip = 1'b1;
        end else if (u < -DEG90) begin
            u = -DEG180 - u; flip = 1'b1;
        end
        rotate(units_to_rad(u < 0 ? -u : u, 0), sn, cs);
        return flip ? -cs : cs;
    endfunction

    function automatic longint half_sine_sq(longint d);
        longint r, sn, cs;
        r = d % DEG360;
        if (r >= DEG180) r -= DEG360;
        if (r < -DEG180) r += DEG360;
        rotate(units_to_rad(r < 0 ? -r : r, 1), sn, cs);
        return qmul(sn, sn);
    endfunction

    function automatic longint half_central_angle(longint plat, longint plon,
                                                  longint tlat, longint tlon);
        longint one, a;
        one = longint'(1) << FRAC;
        a = half_sine_sq(tlat - plat)
          + qmul(qmul(cos_of_lat(plat), cos_of_lat(tlat)), half_sine_sq(tlon - plon));
        if (a < 0) a = 0;
        if (a > one) a = one;
        return vector_angle(root(a << (62 - FRAC)), root((one - a) << (62 - FRAC)));
    endfunction

    function automatic t_distances predict_distances(logic fix, logic signed [30:0] lat,
                                                     logic signed [31:0] lon);
        t_distances d;
        longint     zf, zb;
        d = '0;
        if (fix) begin
            zf = half_central_angle(lat, lon, tgt_front_lat, tgt_front_lon);
            zb = half_central_angle(lat, lon, tgt_back_lat, tgt_back_lon);
            d.ok    = 1'b1;
            d.front = 25'(wide_mul_shift(2 * RADIUS, zf, FRAC));
            d.back  = 25'(wide_mul_shift(2 * RADIUS, zb, FRAC));
            d.mid   = 25'(wide_mul_shift(RADIUS, zf + zb, FRAC));
        end
        return d;
    endfunction

    // ---------------- checking ----------------

    task automatic report(string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("haversine_target_distances_test: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_distances want;
        if (i_rst_n && o_done) begin
            if (pending_dist.size() == 0) begin
                report("result with no item outstanding");
            end else begin
                want = pending_dist.pop_front();
                if (o_dist_ok !== want.ok)
                    report($sformatf("dist_ok %0b want %0b", o_dist_ok, want.ok));
                if (o_front_dist !== want.front)
                    report($sformatf("front_dist %0d want %0d", o_front_dist, want.front));
                if (o_back_dist !== want.back)
                    report($sformatf("back_dist %0d want %0d", o_back_dist, want.back));
                if (o_mid_dist !== want.mid)
                    report($sformatf("mid_dist %0d want %0d", o_mid_dist, want.mid));
            end
        end
    end

    // ---------------- stimulus ----------------

    // start stays high across back-to-back items
    task automatic send_fix(logic fix, logic signed [30:0] lat, logic signed [31:0] lon);
        start     <= 1'b1;
        i_fix_ok  <= fix;
        i_pos_lat <= lat;
        i_pos_lon <= lon;
        do @(posedge i_clk); while (busy);
        pending_dist.push_back(predict_distances(fix, lat, lon));
    endtask

    task automatic maybe_gap();
        if (allow_gaps && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_dist.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(htd_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            htd_pkg::CFG_FRONT_LAT: tgt_front_lat = longint'(signed'(data[30:0]));
            htd_pkg::CFG_FRONT_LON: tgt_front_lon = longint'(signed'(data));
            htd_pkg::CFG_BACK_LAT:  tgt_back_lat  = longint'(signed'(data[30:0]));
            htd_pkg::CFG_BACK_LON:  tgt_back_lon  = longint'(signed'(data));
            default: ;
        endcase
    endtask

    task automatic set_targets(logic [31:0] flat, logic [31:0] flon,
                               logic [31:0] blat, logic [31:0] blon);
        drain();
        write_reg(htd_pkg::CFG_FRONT_LAT, flat);
        write_reg(htd_pkg::CFG_FRONT_LON, flon);
        write_reg(htd_pkg::CFG_BACK_LAT, blat);
        write_reg(htd_pkg::CFG_BACK_LON, blon);
    endtask

    // raw pattern across the whole field width, a range limit, or a value within the limits
    function automatic logic [31:0] rand_coord(longint limit, int bits);
        case ($urandom_range(9))
            0: return 32'($urandom) >> (32 - bits);
            1: return $urandom_range(1) ? 32'(limit) : 32'(-limit);
            default: return 32'(longint'($urandom_range(2 * limit)) - limit);
        endcase
    endfunction

    task automatic test_directed();
        set_targets(32'(400000000), 32'(-1200000000), 32'(-300000000), 32'(1500000000));
        send_fix(1'b0, 31'(400000000), -1200000000);
        send_fix(1'b1, 31'(400000000), -1200000000);       // on the front target
        send_fix(1'b1, 31'(-400000000), 32'(600000000));   // antipode of the front target
        send_fix(1'b1, 31'(LAT_MAX), 0);
        send_fix(1'b1, -31'(LAT_MAX), 0);
        send_fix(1'b1, 0, 32'(LON_MAX));
        send_fix(1'b1, 0, -32'(LON_MAX));
        send_fix(1'b1, 31'h3FFFFFFF, 32'h7FFFFFFF);         // beyond the legal range
        send_fix(1'b1, 31'h40000000, 32'h80000000);
        send_fix(1'b1, 0, 0);
        send_fix(1'b1, 31'd1, -32'd1);
        send_fix(1'b0, 31'h3FFFFFFF, 32'h80000000);
        set_targets(32'(LAT_MAX), 32'(LON_MAX), 32'(-LAT_MAX), 32'(-LON_MAX));
        send_fix(1'b1, 31'(LAT_MAX), -32'(LON_MAX));       // longitude wraps
        send_fix(1'b1, -31'(LAT_MAX), 32'(LON_MAX));
        send_fix(1'b1, 31'h40000000, 32'h7FFFFFFF);
        send_fix(1'b1, 0, 0);
        set_targets(32'h3FFFFFFF, 32'h80000000, 32'hC0000000, 32'h7FFFFFFF);
        send_fix(1'b1, 31'h3FFFFFFF, 32'h80000000);
        send_fix(1'b1, 31'h40000000, 32'h7FFFFFFF);
        send_fix(1'b1, 0, 0);
    endtask

    task automatic random_phase(int n);
        logic [31:0] lat, lon;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(4) == 0) begin
                // close to a target for short distances
                lat = 32'(tgt_front_lat + longint'($urandom_range(20000)) - 10000);
                lon = 32'(tgt_front_lon + longint'($urandom_range(20000)) - 10000);
            end else begin
                lat = rand_coord(LAT_MAX, 31);
                lon = rand_coord(LON_MAX, 32);
            end
            send_fix($urandom_range(9) != 0, lat[30:0], lon);
            maybe_gap();
        end
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_targets(0, 0, 0, 0);
                1: set_targets(32'(LAT_MAX), 32'(-LON_MAX), 32'(-LAT_MAX), 32'(LON_MAX));
                default: set_targets(rand_coord(LAT_MAX, 31), rand_coord(LON_MAX, 32),
                                     rand_coord(LAT_MAX, 31), rand_coord(LON_MAX, 32));
            endcase
            if (p == 5) allow_gaps = 1'b0;
            random_phase(255);
        end
    endtask

    initial begin
        init_tables();
        tgt_front_lat = 0;
        tgt_front_lon = 0;
        tgt_back_lat  = 0;
        tgt_back_lon  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        drain();
        repeat (PIPE_DELAY) @(posedge i_clk);
        if (errors == 0) begin
            $display("haversine_target_distances_test: PASS");
        end else begin
            $display("haversine_target_distances_test: FAIL");
        end
        $finish;
    end

endmodule
